@@ sv/pwsw_pkg.sv @@
package pwsw_pkg;

	localparam int WORD_W = 7;
	localparam int SPEED_N = 6;
	localparam logic [7:0] SPEED_TABLE [SPEED_N] = '{8'd8, 8'd13, 8'd18, 8'd21, 8'd26, 8'd35};

	localparam logic [1:0] REG_PRE_DELAY = 2'd0;
	localparam logic [1:0] REG_SHORT     = 2'd1;
	localparam logic [1:0] REG_LONG      = 2'd2;
	localparam logic [1:0] REG_STOP      = 2'd3;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic [7:0] pre_delay_ticks;
		logic [7:0] short_ticks;
		logic [7:0] long_ticks;
		logic [7:0] stop_ticks;
	} cfg_t;

	typedef struct packed {
		logic       op;
		logic [2:0] motor_mode;
		logic [7:0] spin_period;
		logic       reverse;
	} req_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} res_t;

	// first matching table position, zero when absent
	function automatic logic [2:0] speed_index(input logic [7:0] period);
		logic [2:0] idx;
		logic       found;
		idx = 3'd0;
		found = 1'b0;
		for (int i = 0; i < SPEED_N; i++) begin
			if (!found && SPEED_TABLE[i] == period) begin
				idx = 3'(i);
				found = 1'b1;
			end
		end
		return idx;
	endfunction

endpackage

@@ sv/pulse_width_single_wire_sender_top.sv @@
// channel  dir  signals                              payload
// s        in   s_tvalid s_tready s_tdata s_tuser    request: op, mode, period, reverse
// m        out  m_tvalid m_tready m_tdata m_tlast    line level, busy, frame done
// cfg      in   cfg_we cfg_index cfg_data            timing registers
//
// one request per cycle while s_tready is high; its result is registered in the output buffer
// a two-entry output buffer keeps s_tready high while only one of its entries is full
// s_tready drops only while both output entries are full
// asynchronous reset returns the line high, idle, with default timing
module pulse_width_single_wire_sender_top import pwsw_pkg::*; #(
	parameter int FRAME_BITS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // motor_mode[2:0], spin_period[10:3], reverse[11], zero fill
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // line_level[0], busy_res[1], zero fill
	output logic        m_tlast,   // frame_done
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t cfg_q;
	req_t req;
	res_t res;
	res_t out_q, skid_q;
	logic out_v_q, skid_v_q;
	logic accept;

	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;

	assign req.op          = s_tuser;
	assign req.motor_mode  = s_tdata[2:0];
	assign req.spin_period = s_tdata[10:3];
	assign req.reverse     = s_tdata[11];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_delay_ticks <= 8'd40;
			cfg_q.short_ticks     <= 8'd4;
			cfg_q.long_ticks      <= 8'd8;
			cfg_q.stop_ticks      <= 8'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRE_DELAY: cfg_q.pre_delay_ticks <= cfg_data;
				REG_SHORT:     cfg_q.short_ticks     <= cfg_data;
				REG_LONG:      cfg_q.long_ticks      <= cfg_data;
				REG_STOP:      cfg_q.stop_ticks      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pwsw_core #(
		.FRAME_BITS(FRAME_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (accept),
		.req   (req),
		.cfg   (cfg_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_q.busy_res, out_q.line_level};
	assign m_tlast  = out_q.frame_done;

endmodule

@@ sv/pwsw_core.sv @@
module pwsw_core import pwsw_pkg::*; #(
	parameter int FRAME_BITS = 7
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  req_t req,
	input  cfg_t cfg,
	output res_t res
);

	localparam int BIT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_BITS  = 2'd1,
		PH_STOP  = 2'd2,
		PH_DELAY = 2'd3
	} phase_t;

	logic              sending_q, sending_d;
	phase_t            phase_q, phase_d;
	logic              high_q, high_d;
	logic [7:0]        delay_q, delay_d;
	logic [7:0]        width_q, width_d;
	logic [BIT_W-1:0]  bit_q, bit_d;
	logic [WORD_W-1:0] word_q, word_d;
	logic              wire_q, wire_d;
	logic              done;

	logic [7:0]        w_inc;
	logic [BIT_W:0]    bit_inc;
	logic [15:0]       word_ext;
	logic              bit_val;
	logic [7:0]        high_len;

	always_comb begin
		w_inc    = width_q + 8'd1;
		bit_inc  = {1'b0, bit_q} + {{BIT_W{1'b0}}, 1'b1};
		word_ext = 16'(word_q);
		bit_val  = word_ext[4'(bit_q)];
		high_len = bit_val ? cfg.long_ticks : cfg.short_ticks;

		sending_d = sending_q;
		phase_d   = phase_q;
		high_d    = high_q;
		delay_d   = delay_q;
		width_d   = width_q;
		bit_d     = bit_q;
		word_d    = word_q;
		wire_d    = wire_q;
		done      = 1'b0;

		if (req.op == OP_START) begin
			word_d    = {req.reverse, speed_index(req.spin_period), req.motor_mode};
			sending_d = 1'b1;
			phase_d   = PH_DELAY;
			high_d    = 1'b0;
			delay_d   = 8'd0;
			width_d   = 8'd0;
			bit_d     = '0;
		end else if (sending_q) begin
			case (phase_q)
				PH_DELAY: begin
					if (delay_q == cfg.pre_delay_ticks) begin
						phase_d = PH_START;
					end else begin
						delay_d = delay_q + 8'd1;
					end
				end
				PH_START: begin
					if (!high_q) begin
						wire_d = 1'b0;
						if (width_q >= cfg.long_ticks) begin
							wire_d  = 1'b1;
							high_d  = 1'b1;
							width_d = 8'd0;
						end else begin
							width_d = w_inc;
						end
					end else if (w_inc == cfg.long_ticks) begin
						width_d = 8'd0;
						wire_d  = 1'b0;
						high_d  = 1'b0;
						phase_d = PH_BITS;
					end else begin
						width_d = w_inc;
					end
				end
				PH_BITS: begin
					if (!high_q) begin
						if (w_inc == cfg.short_ticks) begin
							width_d = 8'd0;
							wire_d  = 1'b1;
							high_d  = 1'b1;
						end else begin
							width_d = w_inc;
						end
					end else if (w_inc == high_len) begin
						width_d = 8'd0;
						wire_d  = 1'b0;
						high_d  = 1'b0;
						if (bit_inc >= (BIT_W+1)'(FRAME_BITS)) begin
							bit_d   = '0;
							phase_d = PH_STOP;
						end else begin
							bit_d = bit_inc[BIT_W-1:0];
						end
					end else begin
						width_d = w_inc;
					end
				end
				PH_STOP: begin
					wire_d = 1'b0;
					if (w_inc == cfg.stop_ticks) begin
						width_d   = 8'd0;
						wire_d    = 1'b1;
						phase_d   = PH_START;
						bit_d     = '0;
						sending_d = 1'b0;
						done      = 1'b1;
					end else begin
						width_d = w_inc;
					end
				end
				default: begin
					wire_d    = 1'b1;
					phase_d   = PH_START;
					sending_d = 1'b0;
				end
			endcase
		end

		res.line_level = wire_d;
		res.busy_res   = sending_d;
		res.frame_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			phase_q   <= PH_START;
			high_q    <= 1'b0;
			delay_q   <= 8'd0;
			width_q   <= 8'd0;
			bit_q     <= '0;
			word_q    <= '0;
			wire_q    <= 1'b1;
		end else if (en) begin
			sending_q <= sending_d;
			phase_q   <= phase_d;
			high_q    <= high_d;
			delay_q   <= delay_d;
			width_q   <= width_d;
			bit_q     <= bit_d;
			word_q    <= word_d;
			wire_q    <= wire_d;
		end
	end

endmodule

@@ bench/pulse_width_single_wire_sender_top_tb.sv @@
`timescale 1ns / 1ps

module pulse_width_single_wire_sender_top_tb;
	import pwsw_pkg::*;

	localparam int FRAME_LEN = 7;

	typedef enum logic [1:0] {
		WV_START = 2'd0,
		WV_BITS  = 2'd1,
		WV_STOP  = 2'd2,
		WV_DELAY = 2'd3
	} wave_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	pulse_width_single_wire_sender_top #(
		.FRAME_BITS(FRAME_LEN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// waveform predictor state
	cfg_t        timing = '{pre_delay_ticks: 8'd40, short_ticks: 8'd4,
	                        long_ticks: 8'd8, stop_ticks: 8'd16};
	logic        wv_busy = 1'b0;
	wave_phase_t wv_phase = WV_START;
	logic        wv_high = 1'b0;
	logic [7:0]  wv_delay = '0;
	logic [7:0]  wv_width = '0;
	int          wv_bit = 0;
	logic [6:0]  wv_word = '0;
	logic        wv_level = 1'b1;

	req_t pending_q[$];
	res_t expected_line_q[$];
	req_t shown_req;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int accepted_count = 0;
	int start_count = 0;
	int frames_seen = 0;
	int timing_sets = 0;

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic waveform_step(input req_t r);
		res_t res;
		logic [7:0] span;
		logic done;
		int idx;
		done = 1'b0;
		if (r.op == OP_START) begin
			idx = 0;
			for (int i = SPEED_N - 1; i >= 0; i--)
				if (SPEED_TABLE[i] == r.spin_period)
					idx = i;
			wv_word = {r.reverse, 3'(idx), r.motor_mode};
			wv_busy = 1'b1;
			wv_phase = WV_DELAY;
			wv_high = 1'b0;
			wv_delay = '0;
			wv_width = '0;
			wv_bit = 0;
		end else if (wv_busy) begin
			case (wv_phase)
				WV_DELAY: begin
					if (wv_delay == timing.pre_delay_ticks)
						wv_phase = WV_START;
					else
						wv_delay++;
				end
				WV_START: begin
					if (!wv_high) begin
						wv_level = 1'b0;
						if (wv_width >= timing.long_ticks) begin
							wv_level = 1'b1;
							wv_high = 1'b1;
							wv_width = '0;
						end else begin
							wv_width++;
						end
					end else begin
						wv_width++;
						if (wv_width == timing.long_ticks) begin
							wv_width = '0;
							wv_level = 1'b0;
							wv_high = 1'b0;
							wv_phase = WV_BITS;
						end
					end
				end
				WV_BITS: begin
					if (!wv_high) begin
						wv_width++;
						if (wv_width == timing.short_ticks) begin
							wv_width = '0;
							wv_level = 1'b1;
							wv_high = 1'b1;
						end
					end else begin
						span = wv_word[wv_bit] ? timing.long_ticks : timing.short_ticks;
						wv_width++;
						if (wv_width == span) begin
							wv_width = '0;
							wv_level = 1'b0;
							wv_high = 1'b0;
							wv_bit++;
							if (wv_bit >= FRAME_LEN) begin
								wv_bit = 0;
								wv_phase = WV_STOP;
							end
						end
					end
				end
				WV_STOP: begin
					wv_level = 1'b0;
					wv_width++;
					if (wv_width == timing.stop_ticks) begin
						wv_width = '0;
						wv_level = 1'b1;
						wv_phase = WV_START;
						wv_bit = 0;
						wv_busy = 1'b0;
						done = 1'b1;
					end
				end
				default: begin
					wv_level = 1'b1;
					wv_phase = WV_START;
					wv_busy = 1'b0;
				end
			endcase
		end
		res.line_level = wv_level;
		res.busy_res = wv_busy;
		res.frame_done = done;
		expected_line_q.push_back(res);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("pulse_width_single_wire_sender_top verification failed");
		$finish;
	end

	// request driver
	always @(posedge clk) begin : drv
		logic go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				waveform_step(shown_req);
				accepted_count++;
				if (shown_req.op == OP_START)
					start_count++;
			end
			if (!s_tvalid || s_tready) begin
				go = pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
				if (go) begin
					shown_req = pending_q.pop_front();
					s_tdata <= {4'd0, shown_req.reverse, shown_req.spin_period,
						shown_req.motor_mode};
					s_tuser <= shown_req.op;
				end
				s_tvalid <= go;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : mon
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (m_tlast)
					frames_seen++;
				if (expected_line_q.size() == 0) begin
					flag_mismatch("result with no request pending");
				end else begin
					want = expected_line_q.pop_front();
					if (m_tdata[0] !== want.line_level)
						flag_mismatch($sformatf("line_level %b, expected %b",
							m_tdata[0], want.line_level));
					if (m_tdata[1] !== want.busy_res)
						flag_mismatch($sformatf("busy_res %b, expected %b",
							m_tdata[1], want.busy_res));
					if (m_tlast !== want.frame_done)
						flag_mismatch($sformatf("frame_done %b, expected %b",
							m_tlast, want.frame_done));
				end
			end
			m_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic push_req(input logic op, input logic [2:0] mode,
			input logic [7:0] period, input logic rev);
		req_t r;
		r.op = op;
		r.motor_mode = mode;
		r.spin_period = period;
		r.reverse = rev;
		pending_q.push_back(r);
	endtask

	task automatic push_frame(input logic [2:0] mode, input logic [7:0] period,
			input logic rev, input int ticks);
		push_req(OP_START, mode, period, rev);
		repeat (ticks)
			push_req(OP_TICK, 3'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// upper bound on the ticks one frame needs at the current timing
	function automatic int frame_span();
		int g, w, p;
		g = (timing.short_ticks == 0) ? 256 : int'(timing.short_ticks);
		w = (timing.long_ticks == 0) ? 256 : int'(timing.long_ticks);
		p = (timing.stop_ticks == 0) ? 256 : int'(timing.stop_ticks);
		return int'(timing.pre_delay_ticks) + 3 + 2 * w
			+ FRAME_LEN * (g + ((g > w) ? g : w)) + p;
	endfunction

	task automatic queue_random_frames(input int n_items);
		int queued, n;
		logic [7:0] period;
		queued = 0;
		while (queued < n_items) begin
			if ($urandom_range(1))
				period = SPEED_TABLE[$urandom_range(SPEED_N - 1)];
			else
				period = 8'($urandom);
			if ($urandom_range(99) < 80)
				n = frame_span() + $urandom_range(4);
			else
				n = $urandom_range(frame_span());
			push_frame(3'($urandom), period, 1'($urandom), n);
			queued += n + 1;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PRE_DELAY: timing.pre_delay_ticks = val;
			REG_SHORT:     timing.short_ticks = val;
			REG_LONG:      timing.long_ticks = val;
			REG_STOP:      timing.stop_ticks = val;
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_timing(input logic [7:0] pre_t, input logic [7:0] gap_t,
			input logic [7:0] wide_t, input logic [7:0] stop_t);
		write_reg(REG_PRE_DELAY, pre_t);
		write_reg(REG_SHORT, gap_t);
		write_reg(REG_LONG, wide_t);
		write_reg(REG_STOP, stop_t);
		timing_sets++;
	endtask

	task automatic set_random_timing();
		set_timing(8'($urandom_range(8)), 8'($urandom_range(1, 5)),
			8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || expected_line_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// idle ticks, every speed entry, absent periods, restarts mid frame
		push_req(OP_TICK, 3'd7, 8'd255, 1'b1);
		push_req(OP_TICK, 3'd0, 8'd0, 1'b0);
		push_frame(3'd7, 8'd8, 1'b1, 3);
		push_frame(3'd0, 8'd35, 1'b0, 2);
		for (int i = 1; i < SPEED_N - 1; i++)
			push_frame(3'(i), SPEED_TABLE[i], 1'(i), 1);
		push_frame(3'd5, 8'd0, 1'b1, 1);
		push_frame(3'd2, 8'd255, 1'b0, 1);
		push_frame(3'd3, 8'd9, 1'b1, 1);
		drain();

		set_timing(8'd0, 8'd1, 8'd1, 8'd1);
		queue_random_frames(50);
		drain();

		set_random_timing();
		send_idle_pct = 85;
		queue_random_frames(50);
		drain();

		set_random_timing();
		send_idle_pct = 0;
		recv_stall_pct = 85;
		queue_random_frames(50);
		drain();

		set_random_timing();
		send_idle_pct = 24;
		recv_stall_pct = 24;
		queue_random_frames(60);
		drain();

		set_random_timing();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random_frames(60);
		drain();

		// longest pre-delay, zero stop wraps to 256
		set_timing(8'd255, 8'd1, 8'd1, 8'd0);
		push_frame(3'd0, 8'd0, 1'b0, 540);
		drain();

		// zero long wraps the start high to 256
		set_timing(8'd0, 8'd1, 8'd0, 8'd1);
		push_frame(3'd0, 8'd0, 1'b0, 280);
		drain();

		// zero short wraps the bit gap, then abort
		set_timing(8'd0, 8'd0, 8'd1, 8'd1);
		push_frame(3'd7, 8'd35, 1'b1, 270);
		push_frame(3'd1, 8'd13, 1'b0, 5);
		drain();

		repeat (8) @(posedge clk);
		if (expected_line_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_line_q.size()));
		$display("run: %0d requests (%0d frame starts), %0d frames completed",
			accepted_count, start_count, frames_seen);
		$display("run: %0d timing settings, idle and stall phases, %0d mismatches",
			timing_sets, mismatch_count);
		if (mismatch_count == 0) begin
			$display("pulse_width_single_wire_sender_top verification clean");
		end else begin
			$display("pulse_width_single_wire_sender_top verification failed");
		end
		$finish;
	end

endmodule
